>>> hdl/gmst_pkg.sv
package gmst_pkg;

	// Field widths of one transaction on each channel.
	localparam int OP_W     = 3;
	localparam int SKIP_W   = 3;
	localparam int ANG_W    = 17;
	localparam int OUT_W    = 18;
	localparam int SUM_W    = 18;
	localparam int SPD_W    = 13;
	localparam int STATUS_W = 3;
	localparam int MSTATE_W = 2;
	localparam int LIMIT_W  = 12;

	// Axes that have input fields, limit registers and offsets.
	localparam int IO_AXES = 3;

	// Configuration port.
	localparam int CFG_W     = IO_AXES * ANG_W;
	localparam int CFG_IDX_W = 3;

	// Default parameter values.
	localparam int AXES_DEF            = 3;
	localparam int FRESH_TICKS_DEF     = 15;
	localparam int SETTLE_SQ_LIMIT_DEF = 1000;

	// Register reset values.
	localparam logic signed [ANG_W-1:0] ANGLE_MIN_RST   = -17'sd18000;
	localparam logic signed [ANG_W-1:0] ANGLE_MAX_RST   = 17'sd18000;
	localparam logic [LIMIT_W-1:0]      SPEED_LIMIT_RST = 12'd3600;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_AXIS0_MIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS0_MAX   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS1_MIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS1_MAX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS2_MIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS2_MAX   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSETS     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd7;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_POS_SET     = 3'd0;
	localparam logic [OP_W-1:0] OP_SPEED_SET   = 3'd1;
	localparam logic [OP_W-1:0] OP_SPEED_STOP  = 3'd2;
	localparam logic [OP_W-1:0] OP_POS_REPORT  = 3'd3;
	localparam logic [OP_W-1:0] OP_TICK        = 3'd4;
	localparam logic [OP_W-1:0] OP_POS_QUERY   = 3'd5;
	localparam logic [OP_W-1:0] OP_SPEED_QUERY = 3'd6;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ANGLE_HIGH  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ANGLE_LOW   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_SPEED_HIGH  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_SPEED_LOW   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_READY   = 3'd5;
	localparam logic [STATUS_W-1:0] ST_WRONG_STATE = 3'd6;

	// Motion state codes.
	localparam logic [MSTATE_W-1:0] MS_UNKNOWN = 2'd0;
	localparam logic [MSTATE_W-1:0] MS_KNOWN   = 2'd1;
	localparam logic [MSTATE_W-1:0] MS_MOVING  = 2'd2;
	localparam logic [MSTATE_W-1:0] MS_SPEED   = 2'd3;

endpackage

>>> hdl/gmst_req_if.sv
interface gmst_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [gmst_pkg::OP_W-1:0]             operation;
	logic [gmst_pkg::SKIP_W-1:0]           skip_mask;
	logic signed [gmst_pkg::ANG_W-1:0]     value_axis0;
	logic signed [gmst_pkg::ANG_W-1:0]     value_axis1;
	logic signed [gmst_pkg::ANG_W-1:0]     value_axis2;

	modport source (output valid, operation, skip_mask, value_axis0, value_axis1, value_axis2,
		input ready);
	modport sink (input valid, operation, skip_mask, value_axis0, value_axis1, value_axis2,
		output ready);
endinterface

interface gmst_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic [gmst_pkg::STATUS_W-1:0]         status;
	logic [gmst_pkg::MSTATE_W-1:0]         motion_state;
	logic signed [gmst_pkg::OUT_W-1:0]     out_axis0;
	logic signed [gmst_pkg::OUT_W-1:0]     out_axis1;
	logic signed [gmst_pkg::OUT_W-1:0]     out_axis2;

	modport source (output valid, status, motion_state, out_axis0, out_axis1, out_axis2,
		input ready);
	modport sink (input valid, status, motion_state, out_axis0, out_axis1, out_axis2,
		output ready);
endinterface

>>> hdl/gimbal_motion_state_tracker_top.sv
// Channel   Dir  Transaction
// req       in   operation, skip_mask, value_axis0..2
// rsp       out  status, motion_state, out_axis0..2
// wr_*      in   configuration write: wr_en, wr_index, wr_data
//
// A transaction is taken into the input register, evaluated against the tracker state
// while it waits there and loaded into the result register once that register is free:
// one transaction per cycle sustained while the receiver takes every result. The state
// update in the evaluation step is what sets the rate. Reset clears the tracker state
// and loads the register defaults. A stalled result holds in the result register; the
// input register keeps taking transactions as long as the result register drains or is empty.
module gimbal_motion_state_tracker_top #(
	parameter int AXES            = gmst_pkg::AXES_DEF,
	parameter int FRESH_TICKS     = gmst_pkg::FRESH_TICKS_DEF,
	parameter int SETTLE_SQ_LIMIT = gmst_pkg::SETTLE_SQ_LIMIT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	gmst_req_if.sink                          req,
	gmst_rsp_if.source                        rsp,
	input  logic                              wr_en,
	input  logic [gmst_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [gmst_pkg::CFG_W-1:0]        wr_data
);
	import gmst_pkg::*;

	localparam int FC_W = $clog2(FRESH_TICKS + 1);
	localparam int D_W  = SUM_W + 1;
	localparam int SQ_W = 2 * D_W;
	localparam logic [FC_W-1:0] FRESH_LOAD = FC_W'(FRESH_TICKS);
	localparam logic [SQ_W-1:0] SQ_LIMIT   = SQ_W'(SETTLE_SQ_LIMIT);

	// Configuration registers.
	logic signed [ANG_W-1:0]   min_q [IO_AXES];
	logic signed [ANG_W-1:0]   max_q [IO_AXES];
	logic [CFG_W-1:0]          offsets_q;
	logic [LIMIT_W-1:0]        speed_limit_q;

	// Tracker state.
	logic [MSTATE_W-1:0]       run_state_q;
	logic [FC_W-1:0]           fresh_q;
	logic [AXES-1:0]           settled_q;
	logic signed [ANG_W-1:0]   cur_q [AXES];
	logic signed [SUM_W-1:0]   tgt_q [AXES];
	logic signed [SPD_W-1:0]   spd_q [AXES];

	// Input register.
	logic                      valid_s1;
	logic [OP_W-1:0]           op_s1;
	logic [SKIP_W-1:0]         skip_s1;
	logic signed [ANG_W-1:0]   val_s1 [IO_AXES];

	// Result register.
	logic                      rsp_valid_q;
	logic [STATUS_W-1:0]       status_q;
	logic [MSTATE_W-1:0]       mstate_q;
	logic signed [OUT_W-1:0]   ans_q [IO_AXES];

	logic advance;

	// Per-axis operands and checks.
	logic signed [ANG_W-1:0]   val_ax [AXES];
	logic signed [ANG_W-1:0]   off_ax [AXES];
	logic signed [ANG_W-1:0]   min_ax [AXES];
	logic signed [ANG_W-1:0]   max_ax [AXES];
	logic [AXES-1:0]           skip_ax;
	logic signed [SUM_W-1:0]   pos_sum [AXES];
	logic signed [SUM_W-1:0]   spd_ext [AXES];
	logic signed [D_W-1:0]     err [AXES];
	logic signed [SQ_W-1:0]    err_sq [AXES];
	logic [AXES-1:0]           near;
	logic signed [OUT_W-1:0]   qpos [IO_AXES];
	logic signed [OUT_W-1:0]   qspd [IO_AXES];
	logic signed [SUM_W-1:0]   lim_pos;
	logic signed [SUM_W-1:0]   lim_neg;

	// Next state and result.
	logic [STATUS_W-1:0]       status_n;
	logic [MSTATE_W-1:0]       run_state_n;
	logic [FC_W-1:0]           fresh_n;
	logic [AXES-1:0]           settled_n;
	logic signed [ANG_W-1:0]   cur_n [AXES];
	logic signed [SUM_W-1:0]   tgt_n [AXES];
	logic signed [SPD_W-1:0]   spd_n [AXES];
	logic signed [OUT_W-1:0]   ans_n [IO_AXES];
	logic                      any_speed;

	// Handshake: the input register moves on when the result register is free.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.motion_state = mstate_q;
	assign rsp.out_axis0    = ans_q[0];
	assign rsp.out_axis1    = ans_q[1];
	assign rsp.out_axis2    = ans_q[2];

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < IO_AXES; i++) begin
				min_q[i] <= ANGLE_MIN_RST;
				max_q[i] <= ANGLE_MAX_RST;
			end
			offsets_q     <= '0;
			speed_limit_q <= SPEED_LIMIT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_AXIS0_MIN:   min_q[0]      <= wr_data[ANG_W-1:0];
				REG_AXIS0_MAX:   max_q[0]      <= wr_data[ANG_W-1:0];
				REG_AXIS1_MIN:   min_q[1]      <= wr_data[ANG_W-1:0];
				REG_AXIS1_MAX:   max_q[1]      <= wr_data[ANG_W-1:0];
				REG_AXIS2_MIN:   min_q[2]      <= wr_data[ANG_W-1:0];
				REG_AXIS2_MAX:   max_q[2]      <= wr_data[ANG_W-1:0];
				REG_OFFSETS:     offsets_q     <= wr_data;
				REG_SPEED_LIMIT: speed_limit_q <= wr_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register control and payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1     <= req.operation;
			skip_s1   <= req.skip_mask;
			val_s1[0] <= req.value_axis0;
			val_s1[1] <= req.value_axis1;
			val_s1[2] <= req.value_axis2;
		end
	end

	// Axes beyond the input fields see zero values, zero offsets and default limits.
	for (genvar g = 0; g < AXES; g++) begin : g_axis
		if (g < IO_AXES) begin : g_io
			assign val_ax[g]  = val_s1[g];
			assign off_ax[g]  = offsets_q[g*ANG_W +: ANG_W];
			assign min_ax[g]  = min_q[g];
			assign max_ax[g]  = max_q[g];
			assign skip_ax[g] = skip_s1[g];
		end else begin : g_fixed
			assign val_ax[g]  = '0;
			assign off_ax[g]  = '0;
			assign min_ax[g]  = ANGLE_MIN_RST;
			assign max_ax[g]  = ANGLE_MAX_RST;
			assign skip_ax[g] = 1'b0;
		end

		// Commanded target, speed operand and squared settling error.
		assign pos_sum[g] = SUM_W'(val_ax[g]) + SUM_W'(off_ax[g]);
		assign spd_ext[g] = SUM_W'(val_ax[g]);
		assign err[g]     = D_W'(tgt_q[g]) - D_W'(val_ax[g]);
		assign err_sq[g]  = err[g] * err[g];
		assign near[g]    = $unsigned(err_sq[g]) < SQ_LIMIT;
	end

	// Query answers for the axes that have output fields.
	for (genvar i = 0; i < IO_AXES; i++) begin : g_query
		if (i < AXES) begin : g_live
			assign qpos[i] = OUT_W'(cur_q[i]) - OUT_W'(off_ax[i]);
			assign qspd[i] = OUT_W'(spd_q[i]);
		end else begin : g_none
			assign qpos[i] = '0;
			assign qspd[i] = '0;
		end
	end

	assign lim_pos = SUM_W'(speed_limit_q);
	assign lim_neg = -lim_pos;

	// Evaluation of one transaction against the current state.
	always_comb begin
		status_n    = ST_OK;
		run_state_n = run_state_q;
		fresh_n     = fresh_q;
		settled_n   = settled_q;
		cur_n       = cur_q;
		tgt_n       = tgt_q;
		spd_n       = spd_q;
		any_speed   = 1'b0;
		for (int i = 0; i < IO_AXES; i++) begin
			ans_n[i] = '0;
		end

		unique case (op_s1)
			OP_POS_SET: begin
				// The lowest failing axis decides; too high wins over too low.
				for (int a = 0; a < AXES; a++) begin
					if (status_n == ST_OK && !skip_ax[a]) begin
						if (pos_sum[a] > SUM_W'(max_ax[a])) begin
							status_n = ST_ANGLE_HIGH;
						end else if (pos_sum[a] < SUM_W'(min_ax[a])) begin
							status_n = ST_ANGLE_LOW;
						end
					end
				end
				if (status_n == ST_OK) begin
					settled_n   = settled_q & skip_ax;
					run_state_n = MS_MOVING;
					for (int a = 0; a < AXES; a++) begin
						if (!skip_ax[a]) begin
							tgt_n[a] = pos_sum[a];
						end
					end
				end
			end
			OP_SPEED_SET: begin
				for (int a = 0; a < AXES; a++) begin
					if (status_n == ST_OK && !skip_ax[a]) begin
						if (spd_ext[a] > lim_pos) begin
							status_n = ST_SPEED_HIGH;
						end else if (spd_ext[a] < lim_neg) begin
							status_n = ST_SPEED_LOW;
						end
					end
				end
				if (status_n == ST_OK) begin
					// Speeds kept from earlier commands count as well.
					for (int a = 0; a < AXES; a++) begin
						if (!skip_ax[a]) begin
							spd_n[a] = val_ax[a][SPD_W-1:0];
						end
						any_speed = any_speed || (spd_n[a] != '0);
					end
					run_state_n = any_speed ? MS_SPEED : MS_KNOWN;
				end
			end
			OP_SPEED_STOP: begin
				run_state_n = MS_KNOWN;
				for (int a = 0; a < AXES; a++) begin
					spd_n[a] = '0;
				end
			end
			OP_POS_REPORT: begin
				fresh_n = FRESH_LOAD;
				cur_n   = val_ax;
				if (run_state_q == MS_MOVING) begin
					for (int a = 0; a < AXES; a++) begin
						if (!settled_q[a] && near[a]) begin
							settled_n[a] = 1'b1;
						end
					end
					if (&settled_n) begin
						run_state_n = MS_KNOWN;
					end
				end else if (run_state_q == MS_UNKNOWN) begin
					run_state_n = MS_KNOWN;
				end
			end
			OP_TICK: begin
				if (run_state_q == MS_KNOWN && fresh_q == '0) begin
					run_state_n = MS_UNKNOWN;
				end
				if (fresh_q != '0) begin
					fresh_n = fresh_q - FC_W'(1);
				end
			end
			OP_POS_QUERY: begin
				if (run_state_q != MS_UNKNOWN && fresh_q != '0) begin
					ans_n = qpos;
				end else begin
					status_n = ST_NOT_READY;
				end
			end
			OP_SPEED_QUERY: begin
				if (run_state_q == MS_MOVING) begin
					status_n = ST_WRONG_STATE;
				end else if (run_state_q == MS_SPEED) begin
					ans_n = qspd;
				end
			end
			default: ;
		endcase
	end

	// Tracker state update, once per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_state_q <= MS_UNKNOWN;
			fresh_q     <= '0;
			settled_q   <= '1;
			for (int a = 0; a < AXES; a++) begin
				cur_q[a] <= '0;
				tgt_q[a] <= '0;
				spd_q[a] <= '0;
			end
		end else if (advance) begin
			run_state_q <= run_state_n;
			fresh_q     <= fresh_n;
			settled_q   <= settled_n;
			cur_q       <= cur_n;
			tgt_q       <= tgt_n;
			spd_q       <= spd_n;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_n;
			mstate_q <= run_state_n;
			ans_q    <= ans_n;
		end
	end

endmodule

>>> hdl/gmst_checker.sv
module gmst_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_ready,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic [gmst_pkg::STATUS_W-1:0]     rsp_status,
	input logic [gmst_pkg::MSTATE_W-1:0]     rsp_motion_state,
	input logic [gmst_pkg::OUT_W-1:0]        rsp_out_axis0,
	input logic [gmst_pkg::OUT_W-1:0]        rsp_out_axis1,
	input logic [gmst_pkg::OUT_W-1:0]        rsp_out_axis2
);
	import gmst_pkg::*;

	// A stalled result keeps its status, motion state and first answer field.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_motion_state) && $stable(rsp_out_axis0))
		else $error("result changed while stalled");

	// A result appearing in an empty result register came from a transaction accepted through the input register.
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("result without a matching input transaction");

	// A wrong-state answer is only given while the gimbal moves.
	a_wrong_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_WRONG_STATE |-> rsp_motion_state == MS_MOVING)
		else $error("wrong-state status outside the moving state");

	// Any non-ok status carries zero answer fields.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |->
			rsp_out_axis0 == '0 && rsp_out_axis1 == '0 && rsp_out_axis2 == '0)
		else $error("answer fields set on a failed transaction");

endmodule

bind gimbal_motion_state_tracker_top gmst_checker u_gmst_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_motion_state (rsp.motion_state),
	.rsp_out_axis0    (rsp.out_axis0),
	.rsp_out_axis1    (rsp.out_axis1),
	.rsp_out_axis2    (rsp.out_axis2)
);

>>> tb/tb_gimbal_motion_state_tracker_top.sv
module tb_gimbal_motion_state_tracker_top;
	import gmst_pkg::*;

	localparam int ANGLE_SPAN   = 36000;
	localparam int RESET_CYCLES = 9;
	localparam int DRAIN_CYCLES = 4;
	localparam int PHASE_ITEMS  = 120;
	localparam int MAX_REPORTS  = 10;
	localparam int RUN_LIMIT    = 2000000;

	// Operation code outside the defined set; the block must ignore it.
	localparam logic [OP_W-1:0] OP_UNDEFINED = '1;

	typedef logic [IO_AXES-1:0][ANG_W-1:0] angle_trio_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [SKIP_W-1:0] skip;
		angle_trio_t       val;
	} gimbal_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]           status;
		logic [MSTATE_W-1:0]           mstate;
		logic [IO_AXES-1:0][OUT_W-1:0] ans;
	} gimbal_rsp_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]     wr_data;

	gmst_req_if req_ch ();
	gmst_rsp_if rsp_ch ();

	gimbal_motion_state_tracker_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Commands waiting to be driven and replies the tracker copy predicts.
	gimbal_cmd_t cmd_backlog [$];
	gimbal_rsp_t reply_forecast [$];
	gimbal_cmd_t cmd_on_bus;
	gimbal_rsp_t seen_reply;
	gimbal_rsp_t due_reply;
	bit          cmd_taken;
	int          send_idle_pct;
	int          stall_pct;
	int          gen_count;
	int          fault_count;

	// Configuration copy.
	logic signed [ANG_W-1:0] lim_lo [IO_AXES];
	logic signed [ANG_W-1:0] lim_hi [IO_AXES];
	logic signed [ANG_W-1:0] ofs [IO_AXES];
	logic [LIMIT_W-1:0]      spd_lim;

	// Tracker state copy.
	logic [MSTATE_W-1:0]     mstate;
	logic [7:0]              fresh;
	logic [IO_AXES-1:0]      settled;
	logic signed [ANG_W-1:0] cur [IO_AXES];
	logic signed [SUM_W-1:0] tgt [IO_AXES];
	logic signed [SPD_W-1:0] spd [IO_AXES];

	// Apply one accepted command to the tracker copy and queue the reply it gives.
	function automatic void advance_tracker(gimbal_cmd_t c);
		gimbal_rsp_t r;
		longint sum [IO_AXES];
		longint v;
		longint d;
		longint lim;
		r = '0;
		lim = spd_lim;
		case (c.op)
			OP_POS_SET: begin
				for (int a = 0; a < IO_AXES; a++) begin
					v = $signed(c.val[a]);
					sum[a] = v + ofs[a];
					if (r.status == ST_OK && !c.skip[a]) begin
						if (sum[a] > lim_hi[a])
							r.status = ST_ANGLE_HIGH;
						else if (sum[a] < lim_lo[a])
							r.status = ST_ANGLE_LOW;
					end
				end
				if (r.status == ST_OK) begin
					settled &= c.skip;
					mstate = MS_MOVING;
					for (int a = 0; a < IO_AXES; a++)
						if (!c.skip[a])
							tgt[a] = SUM_W'(sum[a]);
				end
			end
			OP_SPEED_SET: begin
				for (int a = 0; a < IO_AXES; a++) begin
					v = $signed(c.val[a]);
					if (r.status == ST_OK && !c.skip[a]) begin
						if (v > lim)
							r.status = ST_SPEED_HIGH;
						else if (v < -lim)
							r.status = ST_SPEED_LOW;
					end
				end
				if (r.status == ST_OK) begin
					mstate = MS_KNOWN;
					for (int a = 0; a < IO_AXES; a++) begin
						if (!c.skip[a])
							spd[a] = SPD_W'($signed(c.val[a]));
						if (spd[a] != 0)
							mstate = MS_SPEED;
					end
				end
			end
			OP_SPEED_STOP: begin
				mstate = MS_KNOWN;
				for (int a = 0; a < IO_AXES; a++)
					spd[a] = '0;
			end
			OP_POS_REPORT: begin
				fresh = 8'(FRESH_TICKS_DEF);
				for (int a = 0; a < IO_AXES; a++)
					cur[a] = $signed(c.val[a]);
				if (mstate == MS_MOVING) begin
					for (int a = 0; a < IO_AXES; a++) begin
						if (!settled[a]) begin
							d = tgt[a];
							d = d - cur[a];
							if (d * d < SETTLE_SQ_LIMIT_DEF)
								settled[a] = 1'b1;
						end
					end
					if (&settled)
						mstate = MS_KNOWN;
				end else if (mstate == MS_UNKNOWN) begin
					mstate = MS_KNOWN;
				end
			end
			OP_TICK: begin
				if (mstate == MS_KNOWN && fresh == 0)
					mstate = MS_UNKNOWN;
				if (fresh > 0)
					fresh = fresh - 8'd1;
			end
			OP_POS_QUERY: begin
				if (mstate != MS_UNKNOWN && fresh > 0) begin
					for (int a = 0; a < IO_AXES; a++) begin
						v = cur[a];
						v = v - ofs[a];
						r.ans[a] = v[OUT_W-1:0];
					end
				end else begin
					r.status = ST_NOT_READY;
				end
			end
			OP_SPEED_QUERY: begin
				if (mstate == MS_MOVING) begin
					r.status = ST_WRONG_STATE;
				end else if (mstate == MS_SPEED) begin
					for (int a = 0; a < IO_AXES; a++) begin
						v = spd[a];
						r.ans[a] = v[OUT_W-1:0];
					end
				end
			end
			default: begin
			end
		endcase
		r.mstate = mstate;
		reply_forecast.push_back(r);
	endfunction

	// Record a command on the request channel when the handshake completes.
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) begin
			advance_tracker(cmd_on_bus);
			cmd_taken = 1'b1;
		end
	end

	// Present the next command, or go idle, once the previous one is gone.
	always @(negedge clk) begin
		if (arst_n && (!req_ch.valid || cmd_taken)) begin
			cmd_taken = 1'b0;
			if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				cmd_on_bus = cmd_backlog.pop_front();
				req_ch.valid       <= 1'b1;
				req_ch.operation   <= cmd_on_bus.op;
				req_ch.skip_mask   <= cmd_on_bus.skip;
				req_ch.value_axis0 <= cmd_on_bus.val[0];
				req_ch.value_axis1 <= cmd_on_bus.val[1];
				req_ch.value_axis2 <= cmd_on_bus.val[2];
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure.
	always @(negedge clk) begin
		if (arst_n)
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Compare each reply with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			seen_reply.status = rsp_ch.status;
			seen_reply.mstate = rsp_ch.motion_state;
			seen_reply.ans[0] = rsp_ch.out_axis0;
			seen_reply.ans[1] = rsp_ch.out_axis1;
			seen_reply.ans[2] = rsp_ch.out_axis2;
			if (reply_forecast.size() == 0) begin
				fault_count++;
				if (fault_count <= MAX_REPORTS)
					$display("reply with no command pending: status %0d state %0d",
						seen_reply.status, seen_reply.mstate);
			end else begin
				due_reply = reply_forecast.pop_front();
				if (seen_reply != due_reply) begin
					fault_count++;
					if (fault_count <= MAX_REPORTS)
						$display("reply mismatch: expected status %0d state %0d out %0d %0d %0d,",
							due_reply.status, due_reply.mstate, $signed(due_reply.ans[0]),
							$signed(due_reply.ans[1]), $signed(due_reply.ans[2]),
							" got status %0d state %0d out %0d %0d %0d",
							seen_reply.status, seen_reply.mstate, $signed(seen_reply.ans[0]),
							$signed(seen_reply.ans[1]), $signed(seen_reply.ans[2]));
				end
			end
		end
	end

	function automatic angle_trio_t trio(int x0, int x1, int x2);
		angle_trio_t t;
		t[0] = ANG_W'(x0);
		t[1] = ANG_W'(x1);
		t[2] = ANG_W'(x2);
		return t;
	endfunction

	function automatic int any_angle();
		case ($urandom_range(15))
			0: return -ANGLE_SPAN;
			1: return ANGLE_SPAN;
			2: return 0;
			3: return -1;
			default: return int'($urandom_range(2 * ANGLE_SPAN)) - ANGLE_SPAN;
		endcase
	endfunction

	// Angle whose offset sum lands inside the axis window, when one exists.
	function automatic int reachable_angle(int a);
		int t;
		int v;
		if (lim_lo[a] > lim_hi[a])
			return any_angle();
		case ($urandom_range(9))
			0: t = lim_lo[a];
			1: t = lim_hi[a];
			default: t = lim_lo[a] + int'($urandom_range(int'(lim_hi[a]) - int'(lim_lo[a])));
		endcase
		v = t - ofs[a];
		if (v < -ANGLE_SPAN || v > ANGLE_SPAN)
			return any_angle();
		return v;
	endfunction

	function automatic int near_angle(int center, int spread);
		int v;
		v = center + int'($urandom_range(2 * spread)) - spread;
		if (v > ANGLE_SPAN)
			v = ANGLE_SPAN;
		if (v < -ANGLE_SPAN)
			v = -ANGLE_SPAN;
		return v;
	endfunction

	function automatic int any_speed();
		int lim;
		lim = spd_lim;
		case ($urandom_range(7))
			0: return 0;
			1: return lim + 1;
			2: return -lim - 1;
			3: return lim;
			4: return -lim;
			5: return any_angle();
			default: return int'($urandom_range(2 * lim + 20)) - lim - 10;
		endcase
	endfunction

	function automatic int legal_speed();
		int lim;
		lim = spd_lim;
		return int'($urandom_range(2 * lim)) - lim;
	endfunction

	function automatic logic [SKIP_W-1:0] random_skip();
		if ($urandom_range(3) == 0)
			return SKIP_W'($urandom_range(7));
		return '0;
	endfunction

	task automatic push_cmd(logic [OP_W-1:0] op, logic [SKIP_W-1:0] skip, angle_trio_t v);
		gimbal_cmd_t c;
		c.op = op;
		c.skip = skip;
		c.val = v;
		cmd_backlog.push_back(c);
		if (op != OP_UNDEFINED)
			gen_count++;
	endtask

	// Random command of a given operation with values suited to it.
	task automatic push_random(logic [OP_W-1:0] op);
		angle_trio_t v;
		for (int a = 0; a < IO_AXES; a++) begin
			case (op)
				OP_POS_SET: v[a] = ANG_W'(($urandom_range(1) == 0) ? reachable_angle(a)
					: any_angle());
				OP_SPEED_SET: v[a] = ANG_W'(any_speed());
				default: v[a] = ANG_W'(any_angle());
			endcase
		end
		push_cmd(op, random_skip(), v);
	endtask

	task automatic push_mix();
		int r;
		repeat (8) begin
			r = $urandom_range(99);
			if (r < 14)
				push_random(OP_POS_SET);
			else if (r < 26)
				push_random(OP_SPEED_SET);
			else if (r < 32)
				push_random(OP_SPEED_STOP);
			else if (r < 50)
				push_random(OP_POS_REPORT);
			else if (r < 68)
				push_random(OP_TICK);
			else if (r < 84)
				push_random(OP_POS_QUERY);
			else if (r < 98)
				push_random(OP_SPEED_QUERY);
			else
				push_random(OP_UNDEFINED);
		end
	endtask

	// A move followed by reports that close in on the commanded targets.
	task automatic push_move();
		angle_trio_t v;
		int aim [IO_AXES];
		for (int a = 0; a < IO_AXES; a++) begin
			v[a] = ANG_W'(reachable_angle(a));
			aim[a] = $signed(v[a]);
			aim[a] = aim[a] + ofs[a];
		end
		push_cmd(OP_POS_SET, random_skip(), v);
		if ($urandom_range(1) == 0)
			push_random(OP_SPEED_QUERY);
		push_cmd(OP_POS_REPORT, random_skip(), trio(near_angle(aim[0], 400),
			near_angle(aim[1], 400), near_angle(aim[2], 400)));
		push_random(OP_POS_QUERY);
		push_cmd(OP_POS_REPORT, random_skip(), trio(near_angle(aim[0], 25),
			near_angle(aim[1], 25), near_angle(aim[2], 25)));
		if ($urandom_range(1) == 0)
			push_cmd(OP_POS_REPORT, '0, trio(near_angle(aim[0], 0),
				near_angle(aim[1], 0), near_angle(aim[2], 0)));
		push_random(OP_SPEED_QUERY);
	endtask

	// A report, then enough ticks to age the position out around the boundary.
	task automatic push_aging();
		int n;
		n = $urandom_range(17, 13);
		push_random(OP_POS_REPORT);
		repeat (n)
			push_random(OP_TICK);
		push_random(OP_POS_QUERY);
		push_random(OP_TICK);
		push_random(OP_POS_QUERY);
		push_random(OP_SPEED_QUERY);
	endtask

	task automatic push_speed_run();
		push_cmd(OP_SPEED_SET, random_skip(), trio(legal_speed(), legal_speed(), legal_speed()));
		push_random(OP_SPEED_QUERY);
		push_random(OP_SPEED_SET);
		push_random(OP_SPEED_QUERY);
		if ($urandom_range(1) == 0)
			push_random(OP_SPEED_STOP);
		push_random(OP_SPEED_QUERY);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
	endtask

	// Write every register; the block is idle whenever this runs.
	task automatic load_config(angle_trio_t lo, angle_trio_t hi, angle_trio_t of,
		logic [LIMIT_W-1:0] sl);
		write_reg(REG_AXIS0_MIN, CFG_W'($signed(lo[0])));
		write_reg(REG_AXIS0_MAX, CFG_W'($signed(hi[0])));
		write_reg(REG_AXIS1_MIN, CFG_W'($signed(lo[1])));
		write_reg(REG_AXIS1_MAX, CFG_W'($signed(hi[1])));
		write_reg(REG_AXIS2_MIN, CFG_W'($signed(lo[2])));
		write_reg(REG_AXIS2_MAX, CFG_W'($signed(hi[2])));
		write_reg(REG_OFFSETS, of);
		write_reg(REG_SPEED_LIMIT, CFG_W'(sl));
		@(negedge clk);
		wr_en <= 1'b0;
		for (int a = 0; a < IO_AXES; a++) begin
			lim_lo[a] = lo[a];
			lim_hi[a] = hi[a];
			ofs[a]    = of[a];
		end
		spd_lim = sl;
	endtask

	task automatic wait_quiet();
		while (cmd_backlog.size() != 0 || req_ch.valid === 1'b1 || reply_forecast.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(angle_trio_t lo, angle_trio_t hi, angle_trio_t of,
		logic [LIMIT_W-1:0] sl, int send_pct, int hold_pct);
		int kind;
		load_config(lo, hi, of, sl);
		send_idle_pct = send_pct;
		stall_pct     = hold_pct;
		gen_count     = 0;
		while (gen_count < PHASE_ITEMS) begin
			kind = $urandom_range(99);
			if (kind < 45)
				push_mix();
			else if (kind < 65)
				push_move();
			else if (kind < 80)
				push_aging();
			else
				push_speed_run();
		end
		wait_quiet();
	endtask

	// Random window with min not above max.
	function automatic angle_trio_t ordered_lo(angle_trio_t x, angle_trio_t y);
		angle_trio_t t;
		for (int a = 0; a < IO_AXES; a++)
			t[a] = ($signed(x[a]) < $signed(y[a])) ? x[a] : y[a];
		return t;
	endfunction

	initial begin
		angle_trio_t lo;
		angle_trio_t hi;
		angle_trio_t of;
		angle_trio_t x;
		angle_trio_t y;
		req_ch.valid       = 1'b0;
		req_ch.operation   = '0;
		req_ch.skip_mask   = '0;
		req_ch.value_axis0 = '0;
		req_ch.value_axis1 = '0;
		req_ch.value_axis2 = '0;
		rsp_ch.ready       = 1'b0;
		wr_en              = 1'b0;
		wr_index           = '0;
		wr_data            = '0;
		send_idle_pct      = 0;
		stall_pct          = 0;
		fault_count        = 0;
		cmd_taken          = 1'b0;
		for (int a = 0; a < IO_AXES; a++) begin
			lim_lo[a] = ANGLE_MIN_RST;
			lim_hi[a] = ANGLE_MAX_RST;
			ofs[a]    = '0;
			cur[a]    = '0;
			tgt[a]    = '0;
			spd[a]    = '0;
		end
		spd_lim = SPEED_LIMIT_RST;
		mstate  = MS_UNKNOWN;
		fresh   = '0;
		settled = '1;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed commands against the reset configuration.
		push_cmd(OP_TICK, '0, trio(0, 0, 0));
		push_cmd(OP_POS_QUERY, '0, trio(0, 0, 0));
		push_cmd(OP_SPEED_QUERY, '0, trio(0, 0, 0));
		push_cmd(OP_UNDEFINED, 3'b111, trio(-1, -1, -1));
		push_cmd(OP_POS_REPORT, 3'b101, trio(100, -200, 300));
		push_cmd(OP_POS_QUERY, '0, trio(0, 0, 0));
		// Limit violations; the lowest failing axis decides, high before low.
		push_cmd(OP_POS_SET, '0, trio(18001, 0, 0));
		push_cmd(OP_POS_SET, '0, trio(0, -18001, 0));
		push_cmd(OP_POS_SET, '0, trio(18001, -18001, 0));
		// Skipped axes may hold out-of-range values.
		push_cmd(OP_POS_SET, 3'b011, trio(-36000, 36000, 0));
		push_cmd(OP_SPEED_QUERY, '0, trio(0, 0, 0));
		push_cmd(OP_POS_REPORT, '0, trio(0, 0, 31));
		// Settling threshold: an error of 31 settles, 32 does not.
		push_cmd(OP_POS_SET, '0, trio(1000, 1000, 1000));
		push_cmd(OP_POS_REPORT, '0, trio(1031, 968, 1000));
		push_cmd(OP_POS_REPORT, '0, trio(1000, 1000, 1000));
		// Every axis skipped still enters moving.
		push_cmd(OP_POS_SET, 3'b111, trio(20000, -20000, 30000));
		push_cmd(OP_POS_REPORT, '0, trio(5, 5, 5));
		push_cmd(OP_SPEED_SET, '0, trio(3601, 0, 0));
		push_cmd(OP_SPEED_SET, '0, trio(0, -3601, 0));
		push_cmd(OP_SPEED_SET, '0, trio(3600, -3600, 0));
		push_cmd(OP_SPEED_QUERY, '0, trio(0, 0, 0));
		// A kept nonzero speed on a skipped axis holds the speed state.
		push_cmd(OP_SPEED_SET, 3'b110, trio(0, 0, 0));
		push_cmd(OP_SPEED_STOP, '0, trio(0, 0, 0));
		push_cmd(OP_SPEED_QUERY, '0, trio(0, 0, 0));
		push_cmd(OP_POS_SET, '0, trio(18000, -18000, 18000));
		wait_quiet();

		// Widest windows, offsets at both extremes, reset speed limit.
		lo = trio(-ANGLE_SPAN, -ANGLE_SPAN, -ANGLE_SPAN);
		hi = trio(ANGLE_SPAN, ANGLE_SPAN, ANGLE_SPAN);
		of = trio(65535, -65536, 0);
		run_phase(lo, hi, of, SPEED_LIMIT_RST, 0, 0);

		// Random windows, small offsets, random speed limit; sparse sender.
		for (int a = 0; a < IO_AXES; a++) begin
			x[a] = ANG_W'(any_angle());
			y[a] = ANG_W'(any_angle());
			of[a] = ANG_W'(int'($urandom_range(4000)) - 2000);
		end
		lo = ordered_lo(x, y);
		hi = x ^ y ^ lo;
		run_phase(lo, hi, of, LIMIT_W'($urandom_range(SPEED_LIMIT_RST)), 87, 0);

		// Axis 1 window inverted, full-range offsets, zero speed limit; slow receiver.
		for (int a = 0; a < IO_AXES; a++) begin
			x[a] = ANG_W'(any_angle());
			y[a] = ANG_W'(any_angle());
			of[a] = ANG_W'($urandom());
		end
		lo = ordered_lo(x, y);
		hi = x ^ y ^ lo;
		lo[1] = ANG_W'(1000);
		hi[1] = ANG_W'(-1000);
		run_phase(lo, hi, of, '0, 0, 87);

		// Random everything; both sides idle now and then.
		for (int a = 0; a < IO_AXES; a++) begin
			x[a] = ANG_W'(any_angle());
			y[a] = ANG_W'(any_angle());
			of[a] = ANG_W'($urandom());
		end
		lo = ordered_lo(x, y);
		hi = x ^ y ^ lo;
		run_phase(lo, hi, of, LIMIT_W'($urandom_range(SPEED_LIMIT_RST)), 19, 19);

		// Single-point window on axis 0, narrow windows at the range ends.
		lo = trio(0, -ANGLE_SPAN, 35000);
		hi = trio(0, -35000, ANGLE_SPAN);
		for (int a = 0; a < IO_AXES; a++)
			of[a] = ANG_W'(int'($urandom_range(4000)) - 2000);
		run_phase(lo, hi, of, SPEED_LIMIT_RST, 0, 0);

		if (fault_count == 0)
			$display("gimbal_motion_state_tracker_top regression: pass");
		else
			$display("gimbal_motion_state_tracker_top regression: fail");
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("gimbal_motion_state_tracker_top regression: fail");
		$finish;
	end

endmodule

>>> files.f
hdl/gmst_pkg.sv
hdl/gmst_req_if.sv
hdl/gimbal_motion_state_tracker_top.sv
hdl/gmst_checker.sv
tb/tb_gimbal_motion_state_tracker_top.sv
